>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ON_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_ON_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/gttm_pkg.sv
`default_nettype none

package gttm_pkg;

  localparam int NPAR = 5;
  localparam int MODE_W = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int INNER_INDEX_W = 16;
  localparam int OUTER_INDEX_W = 6;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_GREEDY = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_D0_TOL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_Z0_TOL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHI_TOL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_OMEGA_TOL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAN_LAMBDA_TOL = 3'd5;

  localparam int D0_TOL_RESET = 2048;
  localparam int Z0_TOL_RESET = 10240;
  localparam int TOL_OFF = -1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic valid;
    logic live;
    logic [OUTER_INDEX_W-1:0] idx;
  } tag_t;

endpackage

`default_nettype wire

>>> hw/rtl/greedy_tolerance_track_matcher.sv
// Greedy tolerance track matcher.
// Requests arrive on req_valid/req_stall with mode, has_state and five signed track
// parameters. Mode 0 clears the event, mode 1 stores an outer track, mode 2 queries an
// inner track; clear and load give no result.
// A query reads the stored outer tracks from the table memory one per cycle, unless a
// result waits on rsp_stall, through a read, difference and compare path; it holds
// req_stall until all N stored tracks have passed that path, or less long if greedy mode
// stops at the first match. The single table read port sets the rate of one track per cycle.
// Each match gives one result on rsp_valid/rsp_stall; a query with no match gives one
// result with matched low. The last result of a query carries last high.
// A result waits in the output register while rsp_stall is high, and the whole scan path
// halts until it is taken.
// Configuration is to be written through cfg_write, cfg_index and cfg_data only while
// the block is idle; the block does not enforce this. Reset selects greedy mode and the
// default tolerances and empties the event; table contents are not cleared.
`default_nettype none
`include "assert_macros.svh"

module greedy_tolerance_track_matcher #(
  parameter int MAX_OUTER = 64,
  parameter int VALUE_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [gttm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [VALUE_WIDTH-1:0] cfg_data,
  input  wire logic req_valid,
  output logic req_stall,
  input  wire logic [gttm_pkg::MODE_W-1:0] mode,
  input  wire logic has_state,
  input  wire logic signed [VALUE_WIDTH-1:0] d0,
  input  wire logic signed [VALUE_WIDTH-1:0] z0,
  input  wire logic signed [VALUE_WIDTH-1:0] phi,
  input  wire logic signed [VALUE_WIDTH-1:0] omega,
  input  wire logic signed [VALUE_WIDTH-1:0] tan_lambda,
  output logic rsp_valid,
  input  wire logic rsp_stall,
  output logic matched,
  output logic [gttm_pkg::INNER_INDEX_W-1:0] inner_index,
  output logic [gttm_pkg::OUTER_INDEX_W-1:0] outer_index,
  output logic last
);

  localparam int AW = (MAX_OUTER > 1) ? $clog2(MAX_OUTER) : 1;
  localparam int CW = $clog2(MAX_OUTER + 1);
  localparam int EW = gttm_pkg::NPAR * VALUE_WIDTH + 1;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_OUTER);

  gttm_pkg::state_t state, state_next;
  logic greedy;
  logic [gttm_pkg::NPAR-1:0][VALUE_WIDTH-1:0] tol;
  logic [CW-1:0] outer_count;
  logic [gttm_pkg::INNER_INDEX_W-1:0] inner_count;
  logic [MAX_OUTER-1:0] used;
  logic [CW-1:0] scan_idx;
  logic [gttm_pkg::NPAR-1:0][VALUE_WIDTH-1:0] inner_par;
  logic inner_has;
  gttm_pkg::tag_t s1_tag, s1_next, s2_tag;
  logic [EW-1:0] mem [MAX_OUTER];
  logic [EW-1:0] rd_data;
  logic pend_valid;
  logic [gttm_pkg::OUTER_INDEX_W-1:0] pend_idx;

  logic adv, req_acc, load_we, issue, greedy_hit, flush, done, hit;
  logic out_load, out_matched, out_last, pend_set, finish;
  logic [gttm_pkg::OUTER_INDEX_W-1:0] out_idx;

  assign adv = !(rsp_valid && rsp_stall);
  assign req_stall = (state != gttm_pkg::ST_IDLE);
  assign req_acc = req_valid && !req_stall;
  assign load_we = req_acc && (mode == gttm_pkg::MODE_LOAD) && (outer_count < COUNT_MAX);
  assign greedy_hit = hit && greedy;
  assign flush = adv && greedy_hit;
  assign issue = (state == gttm_pkg::ST_SCAN) && adv && (scan_idx < outer_count)
               && !greedy_hit;
  assign done = (state == gttm_pkg::ST_SCAN) && !(scan_idx < outer_count)
              && !s1_tag.valid && !s2_tag.valid;

  always_comb begin
    s1_next.valid = issue;
    s1_next.live = !(greedy && used[scan_idx[AW-1:0]]);
    s1_next.idx = gttm_pkg::OUTER_INDEX_W'(scan_idx[AW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[outer_count[AW-1:0]] <= {has_state, tan_lambda, omega, phi, z0, d0};
    end
    if (adv) begin
      rd_data <= mem[scan_idx[AW-1:0]];
    end
  end

  gttm_match #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_match (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .flush(flush),
    .inner_par(inner_par),
    .inner_has(inner_has),
    .entry(rd_data),
    .tol(tol),
    .tag_in(s1_tag),
    .tag_out(s2_tag),
    .hit(hit)
  );

  // A non-greedy match is held back until the next one shows whether it is the last.
  always_comb begin
    state_next = state;
    out_load = 1'b0;
    out_matched = 1'b0;
    out_idx = '0;
    out_last = 1'b0;
    pend_set = 1'b0;
    finish = 1'b0;
    unique case (state)
      gttm_pkg::ST_IDLE: begin
        if (req_acc && (mode == gttm_pkg::MODE_QUERY)) begin
          state_next = gttm_pkg::ST_SCAN;
        end
      end
      gttm_pkg::ST_SCAN: begin
        if (adv) begin
          if (greedy_hit) begin
            out_load = 1'b1;
            out_matched = 1'b1;
            out_idx = s2_tag.idx;
            out_last = 1'b1;
            finish = 1'b1;
          end else if (hit) begin
            pend_set = 1'b1;
            if (pend_valid) begin
              out_load = 1'b1;
              out_matched = 1'b1;
              out_idx = pend_idx;
            end
          end else if (done) begin
            out_load = 1'b1;
            out_matched = pend_valid;
            out_idx = pend_valid ? pend_idx : '0;
            out_last = 1'b1;
            finish = 1'b1;
          end
        end
        if (finish) begin
          state_next = gttm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gttm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gttm_pkg::ST_IDLE;
      greedy <= 1'b1;
      tol[0] <= VALUE_WIDTH'(gttm_pkg::D0_TOL_RESET);
      tol[1] <= VALUE_WIDTH'(gttm_pkg::Z0_TOL_RESET);
      tol[2] <= VALUE_WIDTH'(gttm_pkg::TOL_OFF);
      tol[3] <= VALUE_WIDTH'(gttm_pkg::TOL_OFF);
      tol[4] <= VALUE_WIDTH'(gttm_pkg::TOL_OFF);
      outer_count <= '0;
      inner_count <= '0;
      used <= '0;
      scan_idx <= '0;
      s1_tag <= '0;
      pend_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          gttm_pkg::CFG_GREEDY: greedy <= cfg_data[0];
          gttm_pkg::CFG_D0_TOL: tol[0] <= cfg_data;
          gttm_pkg::CFG_Z0_TOL: tol[1] <= cfg_data;
          gttm_pkg::CFG_PHI_TOL: tol[2] <= cfg_data;
          gttm_pkg::CFG_OMEGA_TOL: tol[3] <= cfg_data;
          gttm_pkg::CFG_TAN_LAMBDA_TOL: tol[4] <= cfg_data;
          default: begin
          end
        endcase
      end
      if (req_acc) begin
        case (mode)
          gttm_pkg::MODE_CLEAR: begin
            used <= '0;
            outer_count <= '0;
            inner_count <= '0;
          end
          gttm_pkg::MODE_LOAD: begin
            if (outer_count < COUNT_MAX) begin
              outer_count <= outer_count + 1'b1;
            end
          end
          gttm_pkg::MODE_QUERY: begin
            scan_idx <= '0;
          end
          default: begin
          end
        endcase
      end
      if (adv) begin
        s1_tag <= s1_next;
        rsp_valid <= out_load;
      end
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (flush) begin
        used[s2_tag.idx[AW-1:0]] <= 1'b1;
      end
      if (finish) begin
        pend_valid <= 1'b0;
        inner_count <= inner_count + 1'b1;
      end else if (pend_set) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && (mode == gttm_pkg::MODE_QUERY)) begin
      inner_par <= {tan_lambda, omega, phi, z0, d0};
      inner_has <= has_state;
    end
    if (pend_set) begin
      pend_idx <= s2_tag.idx;
    end
    if (adv && out_load) begin
      matched <= out_matched;
      inner_index <= inner_count;
      outer_index <= out_idx;
      last <= out_last;
    end
  end

  `ASSERT_ON_CLK(a_nomatch_form, clk, rst, (rsp_valid && !matched) |-> (last && (outer_index == '0)))
  `ASSERT_ON_CLK(a_idle_empty, clk, rst, (state == gttm_pkg::ST_IDLE) |-> (!s1_tag.valid && !pend_valid))
  `ASSERT_ON_CLK(a_stage_in_scan, clk, rst, s2_tag.valid |-> (state == gttm_pkg::ST_SCAN))
  `ASSERT_ON_CLK(a_used_bound, clk, rst, $countones(used) <= outer_count)

endmodule

`default_nettype wire

>>> hw/rtl/gttm_match.sv
`default_nettype none
`include "assert_macros.svh"

module gttm_match #(
  parameter int VALUE_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic flush,
  input  wire logic [gttm_pkg::NPAR-1:0][VALUE_WIDTH-1:0] inner_par,
  input  wire logic inner_has,
  input  wire logic [gttm_pkg::NPAR*VALUE_WIDTH:0] entry,
  input  wire logic [gttm_pkg::NPAR-1:0][VALUE_WIDTH-1:0] tol,
  input  wire gttm_pkg::tag_t tag_in,
  output gttm_pkg::tag_t tag_out,
  output logic hit
);

  localparam int EW = gttm_pkg::NPAR * VALUE_WIDTH + 1;

  logic [gttm_pkg::NPAR-1:0][VALUE_WIDTH-1:0] entry_par;
  logic entry_has;
  logic signed [VALUE_WIDTH:0] diff [gttm_pkg::NPAR];
  logic signed [VALUE_WIDTH:0] tol_x [gttm_pkg::NPAR];
  logic crit_ok;
  gttm_pkg::tag_t tag_q;

  assign entry_par = entry[EW-2:0];
  assign entry_has = entry[EW-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < gttm_pkg::NPAR; k++) begin
        diff[k] <= {inner_par[k][VALUE_WIDTH-1], inner_par[k]}
                 - {entry_par[k][VALUE_WIDTH-1], entry_par[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q <= '0;
    end else if (flush) begin
      tag_q.valid <= 1'b0;
    end else if (adv) begin
      tag_q.valid <= tag_in.valid;
      tag_q.live <= tag_in.live && inner_has && entry_has;
      tag_q.idx <= tag_in.idx;
    end
  end

  // A negative tolerance switches its criterion off.
  always_comb begin
    crit_ok = 1'b1;
    for (int k = 0; k < gttm_pkg::NPAR; k++) begin
      tol_x[k] = {tol[k][VALUE_WIDTH-1], tol[k]};
      if (!tol[k][VALUE_WIDTH-1]) begin
        if ((diff[k] > tol_x[k]) || (diff[k] < -tol_x[k])) begin
          crit_ok = 1'b0;
        end
      end
    end
  end

  assign hit = tag_q.valid && tag_q.live && crit_ok;
  assign tag_out = tag_q;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int VW = 24;
  localparam int MAX_OUTER = 64;
  localparam int SETTLE_CYCLES = MAX_OUTER + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 160;
  localparam logic [gttm_pkg::MODE_W-1:0] MODE_UNKNOWN = 2'd3;
  localparam logic [VW-1:0] VAL_MAX = 24'h7FFFFF;
  localparam logic [VW-1:0] VAL_MIN = 24'h800000;
  localparam logic [VW-1:0] TOL_MAX = 24'h7FFFFF;

  typedef struct packed {
    logic [gttm_pkg::MODE_W-1:0] mode;
    logic has_state;
    logic [gttm_pkg::NPAR-1:0][VW-1:0] par;
  } track_req_t;

  typedef struct packed {
    logic matched;
    logic [gttm_pkg::INNER_INDEX_W-1:0] inner_index;
    logic [gttm_pkg::OUTER_INDEX_W-1:0] outer_index;
    logic last;
  } match_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [gttm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [VW-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [gttm_pkg::MODE_W-1:0] mode = '0;
  logic has_state = 1'b0;
  logic signed [VW-1:0] d0 = '0;
  logic signed [VW-1:0] z0 = '0;
  logic signed [VW-1:0] phi = '0;
  logic signed [VW-1:0] omega = '0;
  logic signed [VW-1:0] tan_lambda = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic matched;
  logic [gttm_pkg::INNER_INDEX_W-1:0] inner_index;
  logic [gttm_pkg::OUTER_INDEX_W-1:0] outer_index;
  logic last;

  logic signed [VW-1:0] outer_par [MAX_OUTER][gttm_pkg::NPAR];
  logic outer_has [MAX_OUTER];
  logic outer_used [MAX_OUTER] = '{default: 1'b0};
  int outer_count = 0;
  logic [gttm_pkg::INNER_INDEX_W-1:0] inner_count = '0;
  logic greedy_mode = 1'b1;
  logic signed [VW-1:0] tolerance [gttm_pkg::NPAR] = '{
    VW'(gttm_pkg::D0_TOL_RESET), VW'(gttm_pkg::Z0_TOL_RESET),
    VW'(gttm_pkg::TOL_OFF), VW'(gttm_pkg::TOL_OFF), VW'(gttm_pkg::TOL_OFF)};
  match_result_t pending_results[$];
  match_result_t oldest;

  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  int stall_style = 0;
  int stall_left = 0;

  greedy_tolerance_track_matcher #(
    .MAX_OUTER(MAX_OUTER),
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .req_valid, .req_stall, .mode, .has_state,
    .d0, .z0, .phi, .omega, .tan_lambda,
    .rsp_valid, .rsp_stall, .matched, .inner_index, .outer_index, .last
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void predict_matches(input track_req_t r);
    match_result_t held;
    logic have_held;
    logic stop;
    logic hit;
    int a;
    int b;
    int diff;
    case (r.mode)
      gttm_pkg::MODE_CLEAR: begin
        outer_count = 0;
        inner_count = '0;
        for (int i = 0; i < MAX_OUTER; i++) outer_used[i] = 1'b0;
      end
      gttm_pkg::MODE_LOAD: begin
        if (outer_count < MAX_OUTER) begin
          for (int k = 0; k < gttm_pkg::NPAR; k++) outer_par[outer_count][k] = r.par[k];
          outer_has[outer_count] = r.has_state;
          outer_count++;
        end
      end
      gttm_pkg::MODE_QUERY: begin
        have_held = 1'b0;
        stop = 1'b0;
        held = '0;
        for (int i = 0; i < outer_count && !stop; i++) begin
          if (!(greedy_mode && outer_used[i])) begin
            hit = r.has_state && outer_has[i];
            for (int k = 0; k < gttm_pkg::NPAR; k++) begin
              a = $signed(r.par[k]);
              b = outer_par[i][k];
              diff = (a > b) ? a - b : b - a;
              if (tolerance[k] >= 0 && diff > tolerance[k]) hit = 1'b0;
            end
            if (hit) begin
              if (have_held) pending_results.push_back(held);
              held.matched = 1'b1;
              held.inner_index = inner_count;
              held.outer_index = gttm_pkg::OUTER_INDEX_W'(i);
              held.last = 1'b0;
              have_held = 1'b1;
              if (greedy_mode) begin
                outer_used[i] = 1'b1;
                stop = 1'b1;
              end
            end
          end
        end
        if (!have_held) begin
          held.matched = 1'b0;
          held.inner_index = inner_count;
          held.outer_index = '0;
        end
        held.last = 1'b1;
        pending_results.push_back(held);
        inner_count = inner_count + 1'b1;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, inner_index", inner_index, -1);
      end else begin
        oldest = pending_results.pop_front();
        if (matched !== oldest.matched) report_mismatch("matched", matched, oldest.matched);
        if (inner_index !== oldest.inner_index) begin
          report_mismatch("inner_index", inner_index, oldest.inner_index);
        end
        if (outer_index !== oldest.outer_index) begin
          report_mismatch("outer_index", outer_index, oldest.outer_index);
        end
        if (last !== oldest.last) report_mismatch("last", last, oldest.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results pending", $time,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The result side switches at random between stall styles: none, light, periodic and heavy.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 99) < 30);
      2: rsp_stall <= ((stall_left % 8) < 3);
      default: rsp_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  task automatic send_request(input track_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_valid <= 1'b1;
    mode <= r.mode;
    has_state <= r.has_state;
    d0 <= r.par[0];
    z0 <= r.par[1];
    phi <= r.par[2];
    omega <= r.par[3];
    tan_lambda <= r.par[4];
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    predict_matches(r);
    @(negedge clk);
  endtask

  task automatic wait_for_results(input bit settle);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [gttm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [VW-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == gttm_pkg::CFG_GREEDY) greedy_mode = value[0];
    else tolerance[idx - 1] = value;
  endtask

  task automatic apply_settings(input logic g, input logic [VW-1:0] t_d0,
                                input logic [VW-1:0] t_z0, input logic [VW-1:0] t_phi,
                                input logic [VW-1:0] t_omega, input logic [VW-1:0] t_tan);
    logic [VW-1:0] gv;
    gv = VW'($urandom);
    gv[0] = g;
    write_reg(gttm_pkg::CFG_GREEDY, gv);
    write_reg(gttm_pkg::CFG_D0_TOL, t_d0);
    write_reg(gttm_pkg::CFG_Z0_TOL, t_z0);
    write_reg(gttm_pkg::CFG_PHI_TOL, t_phi);
    write_reg(gttm_pkg::CFG_OMEGA_TOL, t_omega);
    write_reg(gttm_pkg::CFG_TAN_LAMBDA_TOL, t_tan);
  endtask

  function automatic track_req_t make_track(input logic [gttm_pkg::MODE_W-1:0] m,
                                            input logic hs,
                                            input logic [VW-1:0] p0, input logic [VW-1:0] p1,
                                            input logic [VW-1:0] p2, input logic [VW-1:0] p3,
                                            input logic [VW-1:0] p4);
    track_req_t r;
    r.mode = m;
    r.has_state = hs;
    r.par[0] = p0;
    r.par[1] = p1;
    r.par[2] = p2;
    r.par[3] = p3;
    r.par[4] = p4;
    return r;
  endfunction

  function automatic track_req_t random_track(input logic [gttm_pkg::MODE_W-1:0] m);
    track_req_t r;
    r.mode = m;
    r.has_state = 1'($urandom_range(0, 1));
    for (int k = 0; k < gttm_pkg::NPAR; k++) r.par[k] = VW'($urandom);
    return r;
  endfunction

  function automatic track_req_t copy_of_outer(input int j);
    track_req_t r;
    r.mode = gttm_pkg::MODE_QUERY;
    r.has_state = 1'b1;
    for (int k = 0; k < gttm_pkg::NPAR; k++) r.par[k] = outer_par[j][k];
    return r;
  endfunction

  function automatic logic [VW-1:0] near_value(input logic signed [VW-1:0] base,
                                               input logic signed [VW-1:0] tol);
    int span;
    int delta;
    if (tol < 0) return VW'($urandom);
    span = (tol > 100000) ? 100000 : int'(tol) + 2;
    if ($urandom_range(0, 3) == 0) delta = int'(tol) + int'($urandom_range(0, 1));
    else delta = $urandom_range(0, span);
    if ($urandom_range(0, 1) == 1) delta = -delta;
    return VW'(int'(base) + delta);
  endfunction

  function automatic track_req_t track_near(input logic [gttm_pkg::MODE_W-1:0] m,
                                            input int near_percent);
    track_req_t r;
    int j;
    r = random_track(m);
    r.has_state = ($urandom_range(0, 9) != 0);
    if (outer_count > 0 && $urandom_range(0, 99) < near_percent) begin
      j = $urandom_range(0, outer_count - 1);
      for (int k = 0; k < gttm_pkg::NPAR; k++) begin
        r.par[k] = near_value(outer_par[j][k], tolerance[k]);
      end
    end
    return r;
  endfunction

  function automatic logic [VW-1:0] pick_tolerance();
    case ($urandom_range(0, 9))
      0, 1: return VW'(gttm_pkg::TOL_OFF);
      2: return '0;
      3: return TOL_MAX;
      4: return VW'($urandom_range(1, 16));
      default: return VW'($urandom_range(16, 8192));
    endcase
  endfunction

  // Default tolerances: exact boundaries on d0 and z0, a track without state, greedy reuse, an unknown mode.
  task automatic test_reset_defaults();
    send_request(make_track(gttm_pkg::MODE_CLEAR, 1'b0, '0, '0, '0, '0, '0));
    send_request(make_track(gttm_pkg::MODE_LOAD, 1'b1, '0, '0, '0, '0, '0));
    send_request(make_track(gttm_pkg::MODE_LOAD, 1'b0, '0, '0, '0, '0, '0));
    send_request(make_track(gttm_pkg::MODE_LOAD, 1'b1, VW'(2049), '0, '0, '0, '0));
    send_request(make_track(gttm_pkg::MODE_LOAD, 1'b1, VW'(2048), VW'(-10240), VAL_MAX,
                            VAL_MIN, VAL_MAX));
    repeat (3) send_request(make_track(gttm_pkg::MODE_QUERY, 1'b1, '0, '0, '0, '0, '0));
    send_request(make_track(gttm_pkg::MODE_QUERY, 1'b0, '0, '0, '0, '0, '0));
    send_request(make_track(MODE_UNKNOWN, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
  endtask

  task automatic test_nongreedy_extremes();
    wait_for_results(1'b1);
    apply_settings(1'b0, '0, TOL_MAX, TOL_MAX, VW'(gttm_pkg::TOL_OFF), '0);
    send_request(make_track(gttm_pkg::MODE_CLEAR, 1'b1, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
                            VAL_MAX));
    repeat (2) begin
      send_request(make_track(gttm_pkg::MODE_LOAD, 1'b1, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
                              VAL_MAX));
    end
    send_request(make_track(gttm_pkg::MODE_LOAD, 1'b1, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
                            VAL_MIN));
    send_request(make_track(gttm_pkg::MODE_LOAD, 1'b1, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
                            VAL_MAX));
    send_request(make_track(gttm_pkg::MODE_QUERY, 1'b1, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
                            VAL_MAX));
    send_request(make_track(gttm_pkg::MODE_QUERY, 1'b1, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
                            VAL_MIN));
    send_request(make_track(gttm_pkg::MODE_QUERY, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN,
                            VAL_MAX));
    send_request(make_track(gttm_pkg::MODE_QUERY, 1'b1, VAL_MAX, VW'(-1), VAL_MAX, VAL_MIN,
                            VAL_MAX));
  endtask

  // Used marks survive a switch out of greedy mode and count again once it returns.
  task automatic test_greedy_toggle();
    track_req_t base;
    track_req_t probe;
    wait_for_results(1'b1);
    apply_settings(1'b1, '0, VW'(gttm_pkg::TOL_OFF), VW'(gttm_pkg::TOL_OFF),
                   VW'(gttm_pkg::TOL_OFF), VW'(gttm_pkg::TOL_OFF));
    send_request(random_track(gttm_pkg::MODE_CLEAR));
    base = random_track(gttm_pkg::MODE_LOAD);
    base.has_state = 1'b1;
    send_request(base);
    send_request(base);
    probe = base;
    probe.mode = gttm_pkg::MODE_QUERY;
    send_request(probe);
    wait_for_results(1'b1);
    write_reg(gttm_pkg::CFG_GREEDY, '0);
    send_request(probe);
    wait_for_results(1'b1);
    write_reg(gttm_pkg::CFG_GREEDY, VW'(1));
    send_request(probe);
    send_request(probe);
  endtask

  task automatic test_table_full();
    track_req_t spare [2];
    track_req_t r;
    wait_for_results(1'b1);
    apply_settings(1'b0, '0, '0, '0, '0, '0);
    send_request(random_track(gttm_pkg::MODE_CLEAR));
    for (int i = 0; i < MAX_OUTER + 2; i++) begin
      r = random_track(gttm_pkg::MODE_LOAD);
      r.has_state = 1'b1;
      if (i >= MAX_OUTER) spare[i - MAX_OUTER] = r;
      send_request(r);
    end
    send_request(copy_of_outer(0));
    send_request(copy_of_outer(MAX_OUTER - 1));
    send_request(copy_of_outer($urandom_range(1, MAX_OUTER - 2)));
    for (int i = 0; i < 2; i++) begin
      r = spare[i];
      r.mode = gttm_pkg::MODE_QUERY;
      send_request(r);
    end
    r = copy_of_outer(MAX_OUTER - 1);
    r.has_state = 1'b0;
    send_request(r);
  endtask

  // Events of clear, loads and queries with random content, plus stray and unknown requests.
  task automatic test_random_events();
    int counted;
    int events;
    int n_load;
    int n_query;
    counted = 0;
    events = 0;
    while (counted < RANDOM_ITEMS) begin
      if (events % 5 == 0) begin
        wait_for_results(1'b1);
        apply_settings(1'($urandom_range(0, 1)), pick_tolerance(), pick_tolerance(),
                       pick_tolerance(), pick_tolerance(), pick_tolerance());
      end else if (events % 5 == 2 || $urandom_range(0, 7) == 0) begin
        wait_for_results(1'b0);
      end
      sender_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0) begin
        send_request(random_track(gttm_pkg::MODE_CLEAR));
        counted++;
      end
      case ($urandom_range(0, 19))
        0: n_load = $urandom_range(20, MAX_OUTER);
        1: n_load = 0;
        default: n_load = $urandom_range(1, 8);
      endcase
      n_query = $urandom_range(1, 10);
      for (int i = 0; i < n_load + n_query; i++) begin
        if ($urandom_range(0, 19) == 0) send_request(random_track(MODE_UNKNOWN));
        if ($urandom_range(0, 49) == 0) send_request(random_track(gttm_pkg::MODE_CLEAR));
        else if (i < n_load) send_request(track_near(gttm_pkg::MODE_LOAD, 40));
        else send_request(track_near(gttm_pkg::MODE_QUERY, 80));
        counted++;
      end
      events++;
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_nongreedy_extremes();
    test_greedy_toggle();
    test_table_full();
    test_random_events();
    wait_for_results(1'b1);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
